/* design/thread_slot_scheduler_defines.svh */
// Assertion macros used by the scheduler top level.
`ifndef THREAD_SLOT_SCHEDULER_DEFINES_SVH
`define THREAD_SLOT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TSS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed");

`endif

/* design/tss_pkg.sv */
// Types and codes of the thread slot scheduler.
package tss_pkg;

	typedef enum logic [1:0] {
		SLOT_UNUSED  = 2'd0,
		SLOT_READY   = 2'd1,
		SLOT_RUNNING = 2'd2,
		SLOT_BLOCKED = 2'd3
	} slot_state_t;

	typedef enum logic [1:0] {
		POL_ROUND_ROBIN = 2'd0,
		POL_LOWEST_SLOT = 2'd1,
		POL_SMALLEST_ID = 2'd2
	} policy_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SAVE,
		SEQ_SCAN,
		SEQ_DRAIN,
		SEQ_FETCH,
		SEQ_OUT
	} seq_state_t;

	// Commands from the sequencer to the slot table
	typedef struct packed {
		logic load;      // write one slot from a write item
		logic save;      // save pointer into current slot, running -> ready
		logic scan_rd;   // read state and id at the scan index
		logic mark_run;  // mark the chosen slot running
		logic stack_rd;  // read the chosen slot's saved pointer
	} tbl_cmd_t;

	localparam int ID_W    = 16;
	localparam int STACK_W = 32;
	localparam int COUNT_W = 32;
	localparam int SLOT_W  = 4;

endpackage

/* design/tss_if.sv */
// Handshake interfaces of the scheduler: request, result and policy write.
interface tss_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [3:0]  slot;
	logic [1:0]  slot_state;
	logic [15:0] slot_id;
	logic [31:0] stack_value;

	modport source (output valid, opcode, slot, slot_state, slot_id, stack_value, input ready);
	modport sink (input valid, opcode, slot, slot_state, slot_id, stack_value, output ready);
endinterface

interface tss_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_stack;
	logic [3:0]  chosen_slot;
	logic        selected;
	logic        switched;
	logic [31:0] switch_count;

	modport source (output valid, next_stack, chosen_slot, selected, switched, switch_count,
		input ready);
	modport sink (input valid, next_stack, chosen_slot, selected, switched, switch_count,
		output ready);
endinterface

interface tss_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] policy;

	modport source (output valid, policy, input ready);
	modport sink (input valid, policy, output ready);
endinterface

/* design/tss_slot_table.sv */
// Slot table: states, thread ids and saved stack pointers with registered scan read.
module tss_slot_table #(
	parameter int SLOTS = 16,
	parameter int IW    = $clog2(SLOTS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tss_pkg::tbl_cmd_t             cmd,
	input  logic [IW-1:0]                 load_idx,
	input  tss_pkg::slot_state_t          load_state,
	input  logic [tss_pkg::ID_W-1:0]      load_id,
	input  logic [tss_pkg::STACK_W-1:0]   stack_wdata,
	input  logic [IW-1:0]                 cur_idx,
	input  logic [IW-1:0]                 scan_idx,
	input  logic [IW-1:0]                 run_idx,
	output logic                          scan_vld_s1,
	output tss_pkg::slot_state_t          state_s1,
	output logic [tss_pkg::ID_W-1:0]      id_s1,
	output logic [IW-1:0]                 idx_s1,
	output logic [tss_pkg::STACK_W-1:0]   stack_rdata_q
);

	tss_pkg::slot_state_t            states_q [SLOTS];
	logic [SLOTS-1:0]                id_vld_q;
	logic [tss_pkg::ID_W-1:0]        id_mem [SLOTS];
	logic [tss_pkg::STACK_W-1:0]     stack_mem [SLOTS];
	logic [IW-1:0]                   st_addr;
	tss_pkg::slot_state_t            st_rd;
	logic [IW-1:0]                   stack_waddr;

	// one read port on the state array, shared by save and scan
	assign st_addr     = cmd.save ? cur_idx : scan_idx;
	assign st_rd       = states_q[st_addr];
	assign stack_waddr = cmd.load ? load_idx : cur_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				states_q[i] <= tss_pkg::SLOT_UNUSED;
			end
			id_vld_q    <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				states_q[load_idx] <= load_state;
				id_vld_q[load_idx] <= 1'b1;
			end else if (cmd.save && st_rd == tss_pkg::SLOT_RUNNING) begin
				states_q[cur_idx] <= tss_pkg::SLOT_READY;
			end else if (cmd.mark_run) begin
				states_q[run_idx] <= tss_pkg::SLOT_RUNNING;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_mem[load_idx] <= load_id;
		end
		if (cmd.load || cmd.save) begin
			stack_mem[stack_waddr] <= stack_wdata;
		end
		if (cmd.stack_rd) begin
			stack_rdata_q <= stack_mem[run_idx];
		end
		if (cmd.scan_rd) begin
			state_s1 <= st_rd;
			id_s1    <= id_vld_q[scan_idx] ? id_mem[scan_idx] : '0;
			idx_s1   <= scan_idx;
		end
	end

endmodule

/* design/tss_pick_unit.sv */
// Shared compare unit: keeps the best ready slot seen during a scan.
module tss_pick_unit #(
	parameter int SLOTS = 16,
	parameter int IW    = $clog2(SLOTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clr,
	input  tss_pkg::policy_t           policy,
	input  logic                       scan_vld_s1,
	input  tss_pkg::slot_state_t       state_s1,
	input  logic [tss_pkg::ID_W-1:0]   id_s1,
	input  logic [IW-1:0]              idx_s1,
	output logic                       found_q,
	output logic [IW-1:0]              best_idx_q
);

	logic [tss_pkg::ID_W-1:0] best_id_q;
	logic                     take;

	// first ready slot wins; by id, only a strictly smaller id replaces it
	assign take = scan_vld_s1 && state_s1 == tss_pkg::SLOT_READY &&
		(!found_q || (policy == tss_pkg::POL_SMALLEST_ID && id_s1 < best_id_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !clr) begin
			best_idx_q <= idx_s1;
			best_id_q  <= id_s1;
		end
	end

endmodule

/* design/thread_slot_scheduler.sv */
// Thread slot scheduler top level: sequencer, output register and policy register.
//
//  channel | dir | handshake           | carries
//  req     | in  | req.valid/req.ready | opcode, slot, slot_state, slot_id, stack_value
//  rsp     | out | rsp.valid/rsp.ready | next_stack, chosen_slot, selected, switched,
//          |     |                     | switch_count
//  cfg     | in  | cfg.valid/cfg.ready | policy
//
// A write item goes straight to result load; a tick runs save (with a current slot only),
// one slot a cycle through the shared compare unit, drain, pointer fetch, result load.
// Reset clears all slot states and ids, the current slot and the switch count; no
// clearing pass. A stalled result holds the sequencer in its last step until taken.
`include "thread_slot_scheduler_defines.svh"

module thread_slot_scheduler #(
	parameter int SLOTS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	tss_req_if.sink   req,
	tss_rsp_if.source rsp,
	tss_cfg_if.sink   cfg
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	tss_pkg::seq_state_t           state_q, state_nxt;
	tss_pkg::policy_t              policy_q;
	tss_pkg::tbl_cmd_t             cmd;
	tss_pkg::opcode_t              op_q;
	logic [tss_pkg::STACK_W-1:0]   stack_q;
	logic [IW-1:0]                 cur_q;
	logic                          cur_valid_q;
	logic [tss_pkg::COUNT_W-1:0]   switches_q;
	logic                          chg_q;
	logic [IW-1:0]                 scan_idx_q;
	logic [CW-1:0]                 cnt_q;
	logic                          accept;
	logic                          load_out;
	logic                          clr_pick;
	logic                          scan_last;
	logic [IW-1:0]                 load_idx;
	logic                          in_range;
	logic [IW-1:0]                 cur_wrap;
	logic [IW-1:0]                 scan_nxt;
	logic [tss_pkg::STACK_W-1:0]   stack_wdata;
	logic                          scan_vld_s1;
	tss_pkg::slot_state_t          state_s1;
	logic [tss_pkg::ID_W-1:0]      id_s1;
	logic [IW-1:0]                 idx_s1;
	logic [tss_pkg::STACK_W-1:0]   stack_rdata_q;
	logic                          found_q;
	logic [IW-1:0]                 best_idx_q;

	assign accept    = req.valid && req.ready;
	assign load_idx  = IW'(req.slot);
	assign in_range  = 32'(req.slot) < SLOTS;
	assign cur_wrap  = (cur_q == IW'(SLOTS - 1)) ? '0 : cur_q + 1'b1;
	assign scan_nxt  = (scan_idx_q == IW'(SLOTS - 1)) ? '0 : scan_idx_q + 1'b1;
	assign scan_last = cnt_q == CW'(SLOTS - 1);
	assign stack_wdata = cmd.load ? req.stack_value : stack_q;
	assign cfg.ready = 1'b1;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req.ready = 1'b0;
		load_out  = 1'b0;
		clr_pick  = 1'b0;
		case (state_q)
			tss_pkg::SEQ_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					clr_pick = 1'b1;
					if (tss_pkg::opcode_t'(req.opcode) == tss_pkg::OP_WRITE) begin
						cmd.load  = in_range;
						state_nxt = tss_pkg::SEQ_OUT;
					end else if (cur_valid_q) begin
						state_nxt = tss_pkg::SEQ_SAVE;
					end else begin
						state_nxt = tss_pkg::SEQ_SCAN;
					end
				end
			end
			tss_pkg::SEQ_SAVE: begin
				cmd.save  = 1'b1;
				state_nxt = tss_pkg::SEQ_SCAN;
			end
			tss_pkg::SEQ_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (scan_last) begin
					state_nxt = tss_pkg::SEQ_DRAIN;
				end
			end
			tss_pkg::SEQ_DRAIN: begin
				state_nxt = tss_pkg::SEQ_FETCH;
			end
			tss_pkg::SEQ_FETCH: begin
				cmd.mark_run = found_q;
				cmd.stack_rd = found_q;
				state_nxt    = tss_pkg::SEQ_OUT;
			end
			tss_pkg::SEQ_OUT: begin
				if (!rsp.valid || rsp.ready) begin
					load_out  = 1'b1;
					state_nxt = tss_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_nxt = tss_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tss_pkg::SEQ_IDLE;
			policy_q    <= tss_pkg::POL_ROUND_ROBIN;
			cur_q       <= '0;
			cur_valid_q <= 1'b0;
			switches_q  <= '0;
			rsp.valid   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// drop policy code 3, keep the previous one
			if (cfg.valid && cfg.policy <= tss_pkg::POL_SMALLEST_ID) begin
				policy_q <= tss_pkg::policy_t'(cfg.policy);
			end
			if (state_q == tss_pkg::SEQ_FETCH && found_q) begin
				cur_q       <= best_idx_q;
				cur_valid_q <= 1'b1;
				if (!cur_valid_q || best_idx_q != cur_q) begin
					switches_q <= switches_q + 1'b1;
				end
			end
			if (load_out) begin
				rsp.valid <= 1'b1;
			end else if (rsp.ready) begin
				rsp.valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= tss_pkg::opcode_t'(req.opcode);
			stack_q <= req.stack_value;
			cnt_q   <= '0;
			// round-robin starts after the current slot; others from slot 0
			if (cur_valid_q && policy_q == tss_pkg::POL_ROUND_ROBIN) begin
				scan_idx_q <= cur_wrap;
			end else begin
				scan_idx_q <= '0;
			end
		end else if (cmd.scan_rd) begin
			cnt_q      <= cnt_q + 1'b1;
			scan_idx_q <= scan_nxt;
		end
		if (state_q == tss_pkg::SEQ_FETCH) begin
			chg_q <= found_q && (!cur_valid_q || best_idx_q != cur_q);
		end
		if (load_out) begin
			if (op_q == tss_pkg::OP_WRITE) begin
				rsp.next_stack  <= '0;
				rsp.chosen_slot <= '0;
				rsp.selected    <= 1'b0;
				rsp.switched    <= 1'b0;
			end else begin
				rsp.next_stack  <= found_q ? stack_rdata_q : stack_q;
				rsp.chosen_slot <= cur_valid_q ? tss_pkg::SLOT_W'(cur_q) : '0;
				rsp.selected    <= found_q;
				rsp.switched    <= chg_q;
			end
			rsp.switch_count <= switches_q;
		end
	end

	tss_slot_table #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.load_idx      (load_idx),
		.load_state    (tss_pkg::slot_state_t'(req.slot_state)),
		.load_id       (req.slot_id),
		.stack_wdata   (stack_wdata),
		.cur_idx       (cur_q),
		.scan_idx      (scan_idx_q),
		.run_idx       (best_idx_q),
		.scan_vld_s1   (scan_vld_s1),
		.state_s1      (state_s1),
		.id_s1         (id_s1),
		.idx_s1        (idx_s1),
		.stack_rdata_q (stack_rdata_q)
	);

	tss_pick_unit #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_pick (
		.clk         (clk),
		.arst_n      (arst_n),
		.clr         (clr_pick),
		.policy      (policy_q),
		.scan_vld_s1 (scan_vld_s1),
		.state_s1    (state_s1),
		.id_s1       (id_s1),
		.idx_s1      (idx_s1),
		.found_q     (found_q),
		.best_idx_q  (best_idx_q)
	);

	`TSS_ASSERT_NEXT(a_busy_after_accept, accept, state_q != tss_pkg::SEQ_IDLE)
	`TSS_ASSERT_NEXT(a_current_sticks, cur_valid_q, cur_valid_q)
	`TSS_ASSERT_NOW(a_save_needs_current, cmd.save, cur_valid_q)
	`TSS_ASSERT_NEXT(a_fetch_makes_current, state_q == tss_pkg::SEQ_FETCH && found_q,
		cur_valid_q && cur_q == $past(best_idx_q))
	`TSS_ASSERT_NOW(a_selected_has_current, rsp.valid && rsp.selected, cur_valid_q)

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the thread slot scheduler: a directed table, then random items.
`timescale 1ns / 1ps

module tb_top;

	localparam int SLOTS        = 16;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 500;
	localparam int PHASES       = 10;
	// Not a policy: the register must keep its old value
	localparam logic [1:0] POL_INVALID = 2'd3;

	typedef struct {
		tss_pkg::opcode_t     op;
		logic [3:0]           slot;
		tss_pkg::slot_state_t state;
		logic [15:0]          id;
		logic [31:0]          sp;
	} sched_req_t;

	typedef struct {
		logic [31:0] next_stack;
		logic [3:0]  chosen_slot;
		logic        selected;
		logic        switched;
		logic [31:0] switch_count;
	} sched_rsp_t;

	typedef enum logic {ROW_ITEM, ROW_POLICY} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		logic [1:0] pol;
		sched_req_t req;
		bit         typed;
		sched_rsp_t rsp;
	} plan_row_t;

	typedef enum logic [1:0] {RX_OPEN, RX_PATTERN, RX_SPARSE} rx_mode_t;

	logic clk;
	logic arst_n;

	tss_req_if req_if();
	tss_rsp_if rsp_if();
	tss_cfg_if cfg_if();

	thread_slot_scheduler #(.SLOTS(SLOTS)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	// Scheduler shadow state
	tss_pkg::slot_state_t tab_state [SLOTS];
	logic [15:0]          tab_id [SLOTS];
	logic [31:0]          tab_sp [SLOTS];
	logic [3:0]           cur_slot;
	bit                   cur_ok;
	logic [31:0]          n_switch;
	tss_pkg::policy_t     cur_pol;

	sched_rsp_t  sched_expect_q [$];
	int unsigned fault_count;
	int          burst_left;

	rx_mode_t    rx_mode;
	int          rx_left;
	logic [15:0] rx_pat;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic flag_fault(input string msg);
		$display("%0t tb_top: %s", $time, msg);
		fault_count++;
	endtask

	function automatic sched_rsp_t schedule_step(input sched_req_t r);
		sched_rsp_t o;
		int         pick;
		logic [3:0] idx;
		o = '{default: '0};
		if (r.op == tss_pkg::OP_WRITE) begin
			tab_state[r.slot] = r.state;
			tab_id[r.slot]    = r.id;
			tab_sp[r.slot]    = r.sp;
			o.switch_count    = n_switch;
			return o;
		end
		// Park the interrupted thread
		if (cur_ok) begin
			tab_sp[cur_slot] = r.sp;
			if (tab_state[cur_slot] == tss_pkg::SLOT_RUNNING)
				tab_state[cur_slot] = tss_pkg::SLOT_READY;
		end
		pick = -1;
		case (cur_pol)
			tss_pkg::POL_LOWEST_SLOT: begin
				for (int i = 0; i < SLOTS; i++)
					if (pick < 0 && tab_state[i] == tss_pkg::SLOT_READY)
						pick = i;
			end
			tss_pkg::POL_SMALLEST_ID: begin
				for (int i = 0; i < SLOTS; i++)
					if (tab_state[i] == tss_pkg::SLOT_READY &&
						(pick < 0 || tab_id[i] < tab_id[pick]))
						pick = i;
			end
			default: begin
				// Round-robin: start after the current slot, try it last
				for (int i = 1; i <= SLOTS; i++) begin
					idx = cur_ok ? cur_slot + 4'(i) : 4'(i - 1);
					if (pick < 0 && tab_state[idx] == tss_pkg::SLOT_READY)
						pick = int'(idx);
				end
			end
		endcase
		if (pick < 0) begin
			o.next_stack   = r.sp;
			o.chosen_slot  = cur_ok ? cur_slot : 4'd0;
			o.switch_count = n_switch;
			return o;
		end
		o.switched = !cur_ok || 4'(pick) != cur_slot;
		if (o.switched)
			n_switch++;
		cur_slot        = 4'(pick);
		cur_ok          = 1'b1;
		tab_state[pick] = tss_pkg::SLOT_RUNNING;
		o.next_stack    = tab_sp[pick];
		o.chosen_slot   = cur_slot;
		o.selected      = 1'b1;
		o.switch_count  = n_switch;
		return o;
	endfunction

	function automatic plan_row_t row_write(input logic [3:0] s,
		input tss_pkg::slot_state_t st, input logic [15:0] id, input logic [31:0] sp,
		input bit typed, input logic [31:0] cnt);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.pol  = '0;
		row.req  = '{op: tss_pkg::OP_WRITE, slot: s, state: st, id: id, sp: sp};
		row.typed = typed;
		row.rsp  = '{next_stack: '0, chosen_slot: '0, selected: 1'b0, switched: 1'b0,
			switch_count: cnt};
		return row;
	endfunction

	// Typed expectation is the echo case: nothing ready and no current slot
	function automatic plan_row_t row_tick(input logic [31:0] sp, input bit typed,
		input logic [31:0] cnt);
		plan_row_t row;
		row.kind = ROW_ITEM;
		row.pol  = '0;
		row.req  = '{op: tss_pkg::OP_TICK, slot: '0, state: tss_pkg::SLOT_UNUSED, id: '0,
			sp: sp};
		row.typed = typed;
		row.rsp  = '{next_stack: sp, chosen_slot: '0, selected: 1'b0, switched: 1'b0,
			switch_count: cnt};
		return row;
	endfunction

	function automatic plan_row_t row_policy(input logic [1:0] p);
		plan_row_t row;
		row = row_tick('0, 1'b0, '0);
		row.kind = ROW_POLICY;
		row.pol  = p;
		return row;
	endfunction

	function automatic sched_req_t rand_req();
		sched_req_t r;
		r.op   = ($urandom_range(0, 9) < 4) ? tss_pkg::OP_TICK : tss_pkg::OP_WRITE;
		r.slot = 4'($urandom_range(0, SLOTS - 1));
		case ($urandom_range(0, 9))
			0, 1:       r.state = tss_pkg::SLOT_UNUSED;
			2, 3, 4, 5: r.state = tss_pkg::SLOT_READY;
			6:          r.state = tss_pkg::SLOT_RUNNING;
			default:    r.state = tss_pkg::SLOT_BLOCKED;
		endcase
		// Small ids half the time so that ties under the id policy are common
		r.id = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		r.sp = $urandom;
		return r;
	endfunction

	task automatic offer(input sched_req_t r, input bit typed, input sched_rsp_t tres);
		sched_rsp_t got;
		int         gap;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_if.valid       <= 1'b1;
		req_if.opcode      <= r.op;
		req_if.slot        <= r.slot;
		req_if.slot_state  <= r.state;
		req_if.slot_id     <= r.id;
		req_if.stack_value <= r.sp;
		do @(posedge clk); while (!req_if.ready);
		got = schedule_step(r);
		if (typed)
			sched_expect_q.push_back(tres);
		else
			sched_expect_q.push_back(got);
	endtask

	// Hold requests back until every result is in
	task automatic settle();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (sched_expect_q.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic set_policy(input logic [1:0] p);
		settle();
		@(negedge clk);
		cfg_if.valid  <= 1'b1;
		cfg_if.policy <= p;
		do @(posedge clk); while (!cfg_if.ready);
		if (p <= tss_pkg::POL_SMALLEST_ID)
			cur_pol = tss_pkg::policy_t'(p);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (rx_left <= 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 2));
			rx_left = $urandom_range(16, 96);
			rx_pat  = 16'($urandom);
		end
		rx_left--;
		rx_pat = {rx_pat[0], rx_pat[15:1]};
		case (rx_mode)
			RX_OPEN:    rsp_if.ready <= 1'b1;
			RX_PATTERN: rsp_if.ready <= rx_pat[0];
			default:    rsp_if.ready <= ($urandom_range(0, 3) != 0);
		endcase
	end

	always @(posedge clk) begin
		sched_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (sched_expect_q.size() == 0) begin
				flag_fault("result with nothing expected");
			end else begin
				want = sched_expect_q.pop_front();
				if (rsp_if.next_stack !== want.next_stack)
					flag_fault($sformatf("next_stack %h, want %h", rsp_if.next_stack,
						want.next_stack));
				if (rsp_if.chosen_slot !== want.chosen_slot)
					flag_fault($sformatf("chosen_slot %0d, want %0d", rsp_if.chosen_slot,
						want.chosen_slot));
				if (rsp_if.selected !== want.selected)
					flag_fault($sformatf("selected %b, want %b", rsp_if.selected,
						want.selected));
				if (rsp_if.switched !== want.switched)
					flag_fault($sformatf("switched %b, want %b", rsp_if.switched,
						want.switched));
				if (rsp_if.switch_count !== want.switch_count)
					flag_fault($sformatf("switch_count %0d, want %0d", rsp_if.switch_count,
						want.switch_count));
			end
		end
	end

	initial begin
		int unsigned cyc;
		cyc = 0;
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		plan_row_t  plan [$];
		sched_rsp_t none;
		logic [1:0] pol_pick;

		arst_n             = 1'b0;
		req_if.valid       = 1'b0;
		req_if.opcode      = tss_pkg::OP_TICK;
		req_if.slot        = '0;
		req_if.slot_state  = tss_pkg::SLOT_UNUSED;
		req_if.slot_id     = '0;
		req_if.stack_value = '0;
		rsp_if.ready       = 1'b0;
		cfg_if.valid       = 1'b0;
		cfg_if.policy      = tss_pkg::POL_ROUND_ROBIN;
		rx_left            = 0;
		burst_left         = 0;
		fault_count        = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tab_state[i] = tss_pkg::SLOT_UNUSED;
			tab_id[i]    = '0;
			tab_sp[i]    = '0;
		end
		cur_slot = '0;
		cur_ok   = 1'b0;
		n_switch = '0;
		cur_pol  = tss_pkg::POL_ROUND_ROBIN;
		none     = '{default: '0};

		// Empty table after reset: echo the pointer
		plan.push_back(row_tick(32'h0000_0000, 1'b1, 32'd0));
		plan.push_back(row_tick(32'hFFFF_FFFF, 1'b1, 32'd0));
		plan.push_back(row_write(4'd15, tss_pkg::SLOT_READY, 16'hFFFF, 32'hFFFF_FFFF,
			1'b1, 32'd0));
		plan.push_back(row_write(4'd0, tss_pkg::SLOT_READY, 16'h0000, 32'h0000_0000,
			1'b1, 32'd0));
		plan.push_back(row_write(4'd7, tss_pkg::SLOT_BLOCKED, 16'h1234, 32'hA5A5_A5A5,
			1'b1, 32'd0));
		// Round-robin from no current, then wrap round
		plan.push_back(row_tick(32'h1111_1111, 1'b0, '0));
		plan.push_back(row_tick(32'h2222_2222, 1'b0, '0));
		plan.push_back(row_tick(32'h3333_3333, 1'b0, '0));
		plan.push_back(row_write(4'd3, tss_pkg::SLOT_RUNNING, 16'h0005, 32'h3C3C_3C3C,
			1'b0, '0));
		plan.push_back(row_write(4'd5, tss_pkg::SLOT_UNUSED, 16'h0001, 32'h5A5A_5A5A,
			1'b0, '0));
		// Same slot chosen again: no switch
		plan.push_back(row_policy(tss_pkg::POL_LOWEST_SLOT));
		plan.push_back(row_tick(32'h4444_4444, 1'b0, '0));
		// Current slot blocked under its feet
		plan.push_back(row_write(4'd0, tss_pkg::SLOT_BLOCKED, 16'h0000, 32'h0000_0000,
			1'b0, '0));
		plan.push_back(row_tick(32'h5555_5555, 1'b0, '0));
		// Equal ids: lower slot wins
		plan.push_back(row_policy(tss_pkg::POL_SMALLEST_ID));
		plan.push_back(row_write(4'd2, tss_pkg::SLOT_READY, 16'h0010, 32'h6666_6666,
			1'b0, '0));
		plan.push_back(row_write(4'd9, tss_pkg::SLOT_READY, 16'h0010, 32'h7777_7777,
			1'b0, '0));
		plan.push_back(row_tick(32'h8888_8888, 1'b0, '0));
		plan.push_back(row_tick(32'h9999_9999, 1'b0, '0));
		plan.push_back(row_policy(POL_INVALID));
		plan.push_back(row_tick(32'hAAAA_AAAA, 1'b0, '0));
		// Nothing ready with a current slot
		plan.push_back(row_write(4'd2, tss_pkg::SLOT_BLOCKED, 16'h0010, 32'hBBBB_BBBB,
			1'b0, '0));
		plan.push_back(row_write(4'd9, tss_pkg::SLOT_BLOCKED, 16'h0010, 32'hCCCC_CCCC,
			1'b0, '0));
		plan.push_back(row_write(4'd15, tss_pkg::SLOT_BLOCKED, 16'hFFFF, 32'hDDDD_DDDD,
			1'b0, '0));
		plan.push_back(row_tick(32'hDEAD_BEEF, 1'b0, '0));
		plan.push_back(row_write(4'd4, tss_pkg::SLOT_READY, 16'h8000, 32'h0123_4567,
			1'b0, '0));
		plan.push_back(row_policy(tss_pkg::POL_ROUND_ROBIN));
		plan.push_back(row_tick(32'hFEDC_BA98, 1'b0, '0));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_POLICY)
				set_policy(plan[k].pol);
			else
				offer(plan[k].req, plan[k].typed, plan[k].rsp);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 3)
				pol_pick = 2'(ph);
			else if ($urandom_range(0, 7) == 0)
				pol_pick = POL_INVALID;
			else
				pol_pick = 2'($urandom_range(0, 2));
			set_policy(pol_pick);
			repeat (RANDOM_ITEMS / PHASES) offer(rand_req(), 1'b0, none);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/tss_pkg.sv
design/tss_if.sv
design/tss_slot_table.sv
design/tss_pick_unit.sv
design/thread_slot_scheduler.sv
tb/tb_top.sv
